// ===== hw/rtl/apsc_pkg.sv =====
// Package for the archive path safety check: state type, reset value,
// reserved device name table and the helper functions shared by the core.
// No dependencies.
`timescale 1ns / 1ps

package apsc_pkg;

    // Bytes with a special role in a path.
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DIGIT_LO  = 8'h31;
    localparam logic [7:0] CHAR_DIGIT_HI  = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;

    // Reserved names: CON, PRN, AUX, NUL, COM, LPT in bits 0 to 5.
    localparam int          NAME_COUNT = 6;
    localparam int          NAME_CHARS = 3;
    localparam logic [NAME_COUNT-1:0] CAND_ALL    = 6'h3F;
    localparam logic [NAME_COUNT-1:0] CAND_SHORT  = 6'h0F;
    localparam logic [NAME_COUNT-1:0] CAND_DEVNUM = 6'h30;

    localparam logic [7:0] NAME_TABLE [NAME_COUNT][NAME_CHARS] = '{
        '{8'h43, 8'h4F, 8'h4E},    // CON
        '{8'h50, 8'h52, 8'h4E},    // PRN
        '{8'h41, 8'h55, 8'h58},    // AUX
        '{8'h4E, 8'h55, 8'h4C},    // NUL
        '{8'h43, 8'h4F, 8'h4D},    // COM
        '{8'h4C, 8'h50, 8'h54}     // LPT
    };

    // Base length saturates here; three and four are the lengths of interest.
    localparam logic [2:0] BASE_SAT     = 3'd5;
    localparam logic [2:0] BASE_SHORT   = 3'd3;
    localparam logic [2:0] BASE_DEVNUM  = 3'd4;

    // Running state of the path scanner.
    typedef struct packed {
        logic                  rejected;
        logic                  at_path_start;
        logic                  component_nonempty;
        logic [2:0]            base_length;
        logic                  base_ended;
        logic [NAME_COUNT-1:0] name_candidates;
        logic                  trailing_char_bad;
        logic                  digit_ok;
    } apsc_state_t;

    localparam apsc_state_t STATE_RESET = '{
        rejected:           1'b0,
        at_path_start:      1'b1,
        component_nonempty: 1'b0,
        base_length:        3'd0,
        base_ended:         1'b0,
        name_candidates:    CAND_ALL,
        trailing_char_bad:  1'b0,
        digit_ok:           1'b0
    };

    // Mask of reserved names whose character at position pos equals up.
    function automatic logic [NAME_COUNT-1:0] name_match(
        input logic [7:0] up,
        input logic [1:0] pos
    );
        logic [NAME_COUNT-1:0] m;
        m = '0;
        for (int k = 0; k < NAME_COUNT; k++)
        begin
            m[k] = (NAME_TABLE[k][pos] == up);
        end
        return m;
    endfunction

    // True when the component described by s must be refused.
    function automatic logic component_bad(input apsc_state_t s);
        logic reserved;
        reserved = ((s.base_length == BASE_SHORT)
                    && ((s.name_candidates & CAND_SHORT) != '0))
                || ((s.base_length == BASE_DEVNUM)
                    && ((s.name_candidates & CAND_DEVNUM) != '0)
                    && s.digit_ok);
        return !s.component_nonempty || s.trailing_char_bad || reserved;
    endfunction

endpackage

// ===== hw/rtl/apsc_step.sv =====
// Combinational next-state logic of the path scanner for one byte.
// Depends on apsc_pkg for the state type, name table and checks.
`timescale 1ns / 1ps

module apsc_step
    import apsc_pkg::*;
(
    input  apsc_state_t cur_state,
    input  logic [7:0]  byte_in,
    input  logic        last_in,
    output apsc_state_t next_state,
    output logic        safe
);

    logic        is_sep;
    logic        reject_now;
    logic [7:0]  up_byte;
    apsc_state_t comp_state;

    assign is_sep  = (byte_in == CHAR_SLASH) || (byte_in == CHAR_BACKSLASH);
    assign up_byte = ((byte_in >= CHAR_LOWER_A) && (byte_in <= CHAR_LOWER_Z))
                   ? (byte_in - CASE_OFFSET) : byte_in;

    // Component bookkeeping for a byte that is not a separator.
    always_comb
    begin
        comp_state = cur_state;
        comp_state.component_nonempty = 1'b1;
        comp_state.trailing_char_bad  = (byte_in == CHAR_DOT)
                                     || (byte_in == CHAR_SPACE);
        if (!cur_state.base_ended)
        begin
            if (byte_in == CHAR_DOT)
            begin
                comp_state.base_ended = 1'b1;
            end
            else
            begin
                if (cur_state.base_length < BASE_SHORT)
                begin
                    comp_state.name_candidates = cur_state.name_candidates
                        & name_match(up_byte, cur_state.base_length[1:0]);
                end
                else if (cur_state.base_length == BASE_SHORT)
                begin
                    comp_state.digit_ok = (byte_in >= CHAR_DIGIT_LO)
                                       && (byte_in <= CHAR_DIGIT_HI);
                end
                if (cur_state.base_length < BASE_SAT)
                begin
                    comp_state.base_length = cur_state.base_length + 3'd1;
                end
            end
        end
    end

    // Path-level checks and the choice of the following state.
    always_comb
    begin
        reject_now = cur_state.rejected
                  || (cur_state.at_path_start && is_sep)
                  || (byte_in == CHAR_COLON)
                  || (byte_in == CHAR_NUL);
        if (is_sep)
        begin
            reject_now = reject_now || component_bad(cur_state);
            next_state = STATE_RESET;
        end
        else
        begin
            reject_now = reject_now || (last_in && component_bad(comp_state));
            next_state = comp_state;
        end
        next_state.rejected      = reject_now;
        next_state.at_path_start = 1'b0;
        safe = !reject_now;
        // A finished path leaves everything as after reset.
        if (last_in)
        begin
            next_state = STATE_RESET;
        end
    end

endmodule

// ===== hw/rtl/archive_path_safety_check_core.sv =====
// Top level of the archive path safety check: input register, scanner state,
// result register and handshakes. Depends on apsc_pkg and apsc_step.
//
//  channel   signals                               direction  width
//  input     in_valid, in_ready, path_byte,        in         8 + 1
//            end_of_path
//  result    out_valid, out_ready, path_is_safe    out        1
//
// One byte is taken every cycle while no final byte waits on a held result;
// the scanner state advances once per byte in a single pass of apsc_step
// between the input and result registers; the final byte's verdict is registered.
// Reset clears the valid bits and returns the scanner to the start of a path.
// A held result stalls only the final byte of the next path; other bytes
// keep flowing while the result waits.
`timescale 1ns / 1ps

module archive_path_safety_check_core
    import apsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] path_byte,
    input  logic       end_of_path,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       path_is_safe
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    apsc_state_t state_reg;
    apsc_state_t state_next;
    logic        out_valid_reg;
    logic        out_safe_reg;
    logic        safe_next;
    logic        stage_fire;

    // The registered byte moves on unless it would produce a result that
    // has nowhere to go.
    assign stage_fire = in_valid_reg
                     && (!in_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !in_valid_reg || stage_fire;

    apsc_step u_step (
        .cur_state  (state_reg),
        .byte_in    (in_byte_reg),
        .last_in    (in_last_reg),
        .next_state (state_next),
        .safe       (safe_next)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= path_byte;
            in_last_reg <= end_of_path;
        end
    end

    // Scanner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (stage_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && in_last_reg)
        begin
            out_safe_reg <= safe_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign path_is_safe = out_safe_reg;

    // A finished path leaves the scanner as after reset.
    a_path_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire && in_last_reg |=> state_reg == STATE_RESET)
        else $error("scanner state not cleared after final byte");

    // A stalled byte in the input register is kept.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !stage_fire |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled byte lost");

    // Base length never passes its saturation value.
    a_base_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.base_length <= BASE_SAT)
        else $error("base length above saturation");

    // The digit flag can only be set once four base bytes have been seen.
    a_digit_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.digit_ok |-> state_reg.base_length >= BASE_DEVNUM)
        else $error("digit flag set with a short base");

endmodule
